/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the heap queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Checks that a consequence holds in the cycle after a condition.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* sv/imhq_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed min-heap queue package
// Operation and status codes and sizes for the heap queue module.
// ----------------------------------------------------------------------------
package imhq_pkg;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_EARLY = 2'd1;
   localparam logic [1:0] OP_LATE  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_NOID  = 2'd2;

   localparam int OP_BITS     = 2;
   localparam int ID_BITS     = 8;
   localparam int CAP_BITS    = 9;
   localparam int MAX_ENTRIES = 256;

endpackage

/* sv/indexed_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// Indexed min-heap queue
// Indexed binary min-heap keyed by event time, held in block memories.
//
// Channel   Direction  Content
// req_      in         op, entry_id, key_time
// rsp_      out        status, assigned_id, front_id, front_key, entry_count,
//                      is_empty
// csr_      in         capacity_limit
//
// A refused item or an unused op skips the sift and goes straight to the front read.
// Each heap level that a sift walks reads the neighbour's id and key; going down it
// also reads the second child's key, so a sift down does more work per level.
// Reset clears the count and restores the capacity; the memories are not
// cleared since no entry at or beyond the count is ever used.
// The result waits in its output register while rsp_ready is low, and no new
// item is taken until it leaves.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue
   import imhq_pkg::*;
#(
   parameter int KEY_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [OP_BITS-1:0]            req_op,
   input  logic [ID_BITS-1:0]            req_entry_id,
   input  logic [31:0]                   req_key_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [ID_BITS-1:0]            rsp_assigned_id,
   output logic [ID_BITS-1:0]            rsp_front_id,
   output logic [31:0]                   rsp_front_key,
   output logic [CAP_BITS-1:0]           rsp_entry_count,
   output logic                          rsp_is_empty,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CAP_BITS-1:0]           csr_data
);
`include "assert_macros.svh"

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = AW + 2;
   localparam int KW = KEY_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_POS_RD, S_POS_GET, S_STEP, S_NB_RD, S_NB_ID, S_NB_KEY,
      S_NB2_KEY, S_DECIDE, S_PLACE, S_FRONT_RD, S_FRONT_ID, S_FRONT_KEY, S_OUT
   } state_type;

   // Heap position to id, and id to its heap position and key.
   logic [AW-1:0]    hid_mem [MAX_ENTRIES];
   logic [AW+KW-1:0] ent_mem [MAX_ENTRIES];

   state_type           state_ff;
   logic [CAP_BITS-1:0] count_ff;
   logic [CAP_BITS-1:0] cap_ff;
   logic [OP_BITS-1:0]  op_ff;
   logic [AW-1:0]       id_ff;
   logic [KW-1:0]       key_ff;
   logic [AW-1:0]       pos_ff;
   logic [AW-1:0]       nb_pos_ff;
   logic [AW-1:0]       nb_id_ff;
   logic [KW-1:0]       nb_key_ff;
   logic [AW-1:0]       nb2_id_ff;
   logic                nb2_ok_ff;
   logic [1:0]          status_ff;
   logic [AW-1:0]       assigned_ff;

   logic [AW-1:0]    hid_q;
   logic [AW+KW-1:0] ent_q;
   logic [AW-1:0]    hid_ra, ent_ra;

   logic [CAP_BITS-1:0] cap_eff;
   logic [CW-1:0]       child1, child2, count_wide;
   logic                id_in_range;
   logic [KW-1:0]       key_in;
   logic                placing, do_swap, mem_we;
   logic [AW-1:0]       mv_id;
   logic [AW+KW-1:0]    ent_wd;

   assign cap_eff = (cap_ff > CAP_BITS'(MAX_ENTRIES)) ? CAP_BITS'(MAX_ENTRIES) : cap_ff;
   assign child1 = {1'b0, pos_ff, 1'b1};
   assign child2 = child1 + CW'(1);
   assign count_wide = CW'(count_ff);
   assign id_in_range = CAP_BITS'(req_entry_id) < count_ff;
   assign key_in = KW'(req_key_time);

   assign placing = (state_ff == S_PLACE);
   assign do_swap = (op_ff == OP_LATE) ? (nb_key_ff < key_ff) : (key_ff < nb_key_ff);
   assign mem_we  = placing || (state_ff == S_DECIDE && do_swap);
   assign mv_id   = placing ? id_ff : nb_id_ff;
   assign ent_wd  = {pos_ff, placing ? key_ff : nb_key_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hid_mem[pos_ff] <= mv_id;
      end
      hid_q <= hid_mem[hid_ra];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ent_mem[mv_id] <= ent_wd;
      end
      ent_q <= ent_mem[ent_ra];
   end

   always_comb begin
      hid_ra = nb_pos_ff;
      ent_ra = id_ff;
      case (state_ff)
         S_NB_ID: begin
            hid_ra = child2[AW-1:0];
            ent_ra = hid_q;
         end
         S_NB_KEY:   ent_ra = hid_q;
         S_FRONT_RD: hid_ra = '0;
         S_FRONT_ID: ent_ra = hid_q;
         default:    ent_ra = id_ff;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         cap_ff    <= CAP_BITS'(MAX_ENTRIES);
         rsp_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff  <= req_op;
                  key_ff <= key_in;
                  if (req_op == OP_ADD && count_ff < cap_eff) begin
                     id_ff       <= AW'(count_ff);
                     pos_ff      <= AW'(count_ff);
                     assigned_ff <= AW'(count_ff);
                     count_ff    <= count_ff + CAP_BITS'(1);
                     status_ff   <= ST_OK;
                     state_ff    <= S_STEP;
                  end else if ((req_op == OP_EARLY || req_op == OP_LATE) && id_in_range) begin
                     id_ff       <= AW'(req_entry_id);
                     assigned_ff <= '0;
                     status_ff   <= ST_OK;
                     state_ff    <= S_POS_RD;
                  end else begin
                     assigned_ff <= '0;
                     if (req_op == OP_ADD) begin
                        status_ff <= ST_FULL;
                     end else if (req_op == OP_EARLY || req_op == OP_LATE) begin
                        status_ff <= ST_NOID;
                     end else begin
                        status_ff <= ST_OK;
                     end
                     state_ff <= S_FRONT_RD;
                  end
               end
            end
            S_POS_RD: state_ff <= S_POS_GET;
            S_POS_GET: begin
               pos_ff   <= ent_q[AW+KW-1:KW];
               state_ff <= S_STEP;
            end
            S_STEP: begin
               if (op_ff == OP_LATE) begin
                  if (child1 < count_wide) begin
                     nb_pos_ff <= child1[AW-1:0];
                     nb2_ok_ff <= (child2 < count_wide);
                     state_ff  <= S_NB_RD;
                  end else begin
                     state_ff <= S_PLACE;
                  end
               end else if (pos_ff != '0) begin
                  nb_pos_ff <= (pos_ff - AW'(1)) >> 1;
                  nb2_ok_ff <= 1'b0;
                  state_ff  <= S_NB_RD;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_NB_RD: state_ff <= S_NB_ID;
            S_NB_ID: begin
               nb_id_ff <= hid_q;
               state_ff <= S_NB_KEY;
            end
            S_NB_KEY: begin
               nb_key_ff <= ent_q[KW-1:0];
               nb2_id_ff <= hid_q;
               state_ff  <= nb2_ok_ff ? S_NB2_KEY : S_DECIDE;
            end
            S_NB2_KEY: begin
               // The second child wins only when its key is strictly smaller.
               if (ent_q[KW-1:0] < nb_key_ff) begin
                  nb_key_ff <= ent_q[KW-1:0];
                  nb_id_ff  <= nb2_id_ff;
                  nb_pos_ff <= child2[AW-1:0];
               end
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (do_swap) begin
                  pos_ff   <= nb_pos_ff;
                  state_ff <= S_STEP;
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: state_ff <= S_FRONT_RD;
            S_FRONT_RD: state_ff <= S_FRONT_ID;
            S_FRONT_ID: begin
               rsp_front_id <= (count_ff == '0) ? '0 : ID_BITS'(hid_q);
               state_ff     <= S_FRONT_KEY;
            end
            S_FRONT_KEY: begin
               rsp_valid       <= 1'b1;
               rsp_status      <= status_ff;
               rsp_assigned_id <= ID_BITS'(assigned_ff);
               rsp_front_key   <= (count_ff == '0) ? 32'd0 : 32'(ent_q[KW-1:0]);
               rsp_entry_count <= count_ff;
               rsp_is_empty    <= (count_ff == '0);
               state_ff        <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLY(a_count_cap, clock, reset, 1'b1, count_ff <= CAP_BITS'(MAX_ENTRIES), "count too big")
   `ASSERT_IMPLY(a_ready_idle, clock, reset, rsp_valid, !req_ready, "accept while result pending")
   `ASSERT_IMPLY(a_empty, clock, reset, rsp_valid, rsp_is_empty == (rsp_entry_count == '0), "empty flag mismatch")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_front_key) && $stable(rsp_front_id),
                "result changed while waiting")

endmodule
